/* rtl/core/phcp_pkg.sv */
// Shared types, widths and codes for the page home-core placement policy block.
package phcp_pkg;

	localparam int PAGE_W        = 10;
	localparam int COUNT_W       = 32;
	localparam int CORE_W        = 6;
	localparam int MODE_W        = 2;
	localparam int SHIFT_W       = 5;
	localparam int PLACE_W       = 2;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 5;
	localparam int NUM_CORES_DEF = 64;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOMINANCE_SHIFT = 4'd1;

	localparam logic [MODE_W-1:0] MODE_HASH_ALL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HOTTEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DOMINATE = 2'd2;

	localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_DOMINATE;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd1;

	typedef enum logic [PLACE_W-1:0] {
		PLACE_NONE = 2'd0,
		PLACE_HASH = 2'd1,
		PLACE_HOME = 2'd2
	} place_t;

	typedef struct packed {
		logic               fire;
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] best;
		logic [CORE_W-1:0]  core;
		logic [COUNT_W-1:0] total;
	} page_sum_t;

endpackage

/* rtl/core/phcp_accum.sv */
// Input register and per-page running maximum, hottest core and total.
module phcp_accum import phcp_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PAGE_W-1:0]  in_page,
	input  logic [COUNT_W-1:0] in_count,
	input  logic               slot_free,
	output page_sum_t          sum,
	output logic               busy
);

	localparam int POS_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_CORES - 1);

	logic               valid_s1;
	logic [PAGE_W-1:0]  page_s1;
	logic [COUNT_W-1:0] count_s1;

	logic [POS_W-1:0]   pos_q;
	logic [COUNT_W-1:0] best_q;
	logic [POS_W-1:0]   core_q;
	logic [COUNT_W-1:0] total_q;

	logic               last;
	logic               advance;
	logic               take;
	logic [COUNT_W-1:0] cand_best;
	logic [POS_W-1:0]   cand_core;
	logic [COUNT_W-1:0] cand_total;

	assign last       = (pos_q == LAST_POS);
	assign advance    = valid_s1 && (!last || slot_free);
	assign in_ready   = !valid_s1 || advance;
	assign busy       = valid_s1;
	assign take       = (count_s1 > best_q);
	assign cand_best  = take ? count_s1 : best_q;
	assign cand_core  = take ? pos_q : core_q;
	assign cand_total = total_q + count_s1;

	always_comb begin
		sum.fire  = advance && last;
		sum.page  = page_s1;
		sum.best  = cand_best;
		sum.core  = CORE_W'(cand_core);
		sum.total = cand_total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_s1  <= in_page;
			count_s1 <= in_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			best_q  <= '0;
			core_q  <= '0;
			total_q <= '0;
		end else if (advance) begin
			if (last) begin
				pos_q   <= '0;
				best_q  <= '0;
				core_q  <= '0;
				total_q <= '0;
			end else begin
				pos_q   <= pos_q + POS_W'(1);
				best_q  <= cand_best;
				core_q  <= cand_core;
				total_q <= cand_total;
			end
		end
	end

endmodule

/* rtl/core/phcp_decide.sv */
// Placement decision and output register.
module phcp_decide import phcp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  page_sum_t          sum,
	input  logic [MODE_W-1:0]  policy_mode,
	input  logic [SHIFT_W-1:0] dominance_shift,
	output logic               slot_free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PAGE_W-1:0]  page_out,
	output logic [PLACE_W-1:0] placement,
	output logic [CORE_W-1:0]  home_core
);

	place_t             place;
	logic [COUNT_W-1:0] limit;
	logic               out_valid_q;
	logic [PAGE_W-1:0]  page_q;
	place_t             place_q;
	logic [CORE_W-1:0]  home_q;

	assign limit     = sum.total >> dominance_shift;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		case (policy_mode)
			MODE_HASH_ALL: place = PLACE_HASH;
			MODE_HOTTEST:  place = (sum.best != '0) ? PLACE_HOME : PLACE_NONE;
			default: begin
				if (sum.best == '0) begin
					place = PLACE_NONE;
				end else if (sum.best < limit) begin
					place = PLACE_HASH;
				end else begin
					place = PLACE_HOME;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= sum.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (sum.fire && slot_free) begin
			page_q  <= sum.page;
			place_q <= place;
			home_q  <= (place == PLACE_HOME) ? sum.core : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign page_out  = page_q;
	assign placement = place_q;
	assign home_core = home_q;

endmodule

/* rtl/core/page_home_core_placement_policy_top.sv */
// Page home-core placement policy: top level with configuration registers.
//
// Input stream s_axis carries one access count per beat, cores in order
// 0 .. NUM_CORES-1 for each page. After the beat of the last core the block
// emits one beat on m_axis with the page's placement: 0 no change, 1 hash,
// 2 home on the hottest core (lowest index on ties) given in home_core.
// Configuration writes go through the cfg channel (index 0 policy_mode,
// index 1 dominance_shift, other indexes ignored); cfg_ready is always high.
// Write registers only while no page is in flight.
// Throughput: one count beat per cycle while the final beat of a page is not held
// by a stalled output, set by the combinational compare and add of the accumulator.
// The last core's beat passes the input register, then the output register, to m_axis.
// When m_axis stalls, the output register holds its beat; count beats of
// non-final cores still flow, and only the final beat of the next page waits.
// Reset clears the accumulators and all valid flags, and sets policy_mode to
// dominance test and dominance_shift to 1.
module page_home_core_placement_policy_top import phcp_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] page_number, [41:10] access_count
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [9:0] page_out, [11:10] placement, [17:12] home_core
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [MODE_W-1:0]  mode_q;
	logic [SHIFT_W-1:0] shift_q;
	page_sum_t          sum;
	logic               slot_free;
	logic               busy;
	logic [PAGE_W-1:0]  page_out;
	logic [PLACE_W-1:0] placement;
	logic [CORE_W-1:0]  home_core;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			shift_q <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLICY_MODE:     mode_q  <= cfg_data[MODE_W-1:0];
				REG_DOMINANCE_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	phcp_accum #(
		.NUM_CORES(NUM_CORES)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_page  (s_axis_tdata[PAGE_W-1:0]),
		.in_count (s_axis_tdata[PAGE_W+COUNT_W-1:PAGE_W]),
		.slot_free(slot_free),
		.sum      (sum),
		.busy     (busy)
	);

	phcp_decide u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.sum            (sum),
		.policy_mode    (mode_q),
		.dominance_shift(shift_q),
		.slot_free      (slot_free),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.page_out       (page_out),
		.placement      (placement),
		.home_core      (home_core)
	);

	assign m_axis_tdata = {(M_TDATA_W - PAGE_W - PLACE_W - CORE_W)'(0), home_core, placement,
		page_out};

`ifndef SYNTHESIS
	a_ready_low_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> busy && !slot_free)
		else $error("input stalled without a pending final beat");

	a_home_only_home: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && placement != PLACE_HOME |-> home_core == '0)
		else $error("home_core nonzero without home placement");

	a_place_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> placement == PLACE_NONE || placement == PLACE_HASH ||
			placement == PLACE_HOME)
		else $error("illegal placement code");

	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		sum.fire |=> m_axis_tvalid && page_out == $past(sum.page))
		else $error("final beat did not reach the output register");
`endif

endmodule

/* sim/page_home_core_placement_policy_top_tb.sv */
// Self-checking testbench for the page home-core placement policy block.
module page_home_core_placement_policy_top_tb import phcp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                    WATCHDOG_LIMIT   = 2000;
	localparam logic [MODE_W-1:0]     MODE_UNUSED      = 2'd3;
	localparam logic [CFG_IDX_W-1:0]  REG_FIRST_UNUSED = 4'd2;

	typedef enum int {
		PG_ZERO, PG_SPARSE, PG_DOMINANT, PG_RANDOM, PG_TIES, PG_SATURATED, PG_SPREAD
	} page_kind_t;

	typedef struct {
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] count;
	} count_beat_t;

	typedef struct {
		logic [PAGE_W-1:0] page;
		place_t            place;
		logic [CORE_W-1:0] core;
	} placement_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	count_beat_t beat_q[$];
	placement_t  placement_q[$];

	// block state as predicted
	int                 core_pos;
	logic [COUNT_W-1:0] best_count;
	logic [CORE_W-1:0]  best_core;
	logic [COUNT_W-1:0] page_total;
	logic [MODE_W-1:0]  mode_q;
	logic [SHIFT_W-1:0] shift_q;

	logic s_taken = 1'b0;
	int   cfg_beats = 0;
	int   err_cnt = 0;
	int   quiet_cycles = 0;
	int   src_pct = 0;
	int   snk_pct = 0;
	int   src_gap = 0;
	int   snk_gap = 0;

	page_home_core_placement_policy_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic tally_count(input logic [PAGE_W-1:0] page, input logic [COUNT_W-1:0] count);
		placement_t res;
		page_total = page_total + count;
		if (count > best_count) begin
			best_count = count;
			best_core  = CORE_W'(core_pos);
		end
		if (core_pos < NUM_CORES_DEF - 1) begin
			core_pos++;
		end else begin
			res.page = page;
			res.core = '0;
			if (mode_q == MODE_HASH_ALL) begin
				res.place = PLACE_HASH;
			end else if (mode_q == MODE_HOTTEST) begin
				res.place = (best_count != 0) ? PLACE_HOME : PLACE_NONE;
			end else if (best_count == 0) begin
				res.place = PLACE_NONE;
			end else if (best_count < (page_total >> shift_q)) begin
				res.place = PLACE_HASH;
			end else begin
				res.place = PLACE_HOME;
			end
			if (res.place == PLACE_HOME)
				res.core = best_core;
			placement_q.push_back(res);
			core_pos   = 0;
			best_count = '0;
			best_core  = '0;
			page_total = '0;
		end
	endtask

	task automatic check_placement(input logic [M_TDATA_W-1:0] beat);
		placement_t want;
		logic [PAGE_W-1:0]  got_page;
		logic [PLACE_W-1:0] got_place;
		logic [CORE_W-1:0]  got_core;
		got_page  = beat[PAGE_W-1:0];
		got_place = beat[PAGE_W +: PLACE_W];
		got_core  = beat[PAGE_W+PLACE_W +: CORE_W];
		if (placement_q.size() == 0) begin
			$error("unexpected result beat: page_out %0d placement %0d home_core %0d",
				got_page, got_place, got_core);
			err_cnt++;
		end else begin
			want = placement_q.pop_front();
			if (got_page !== want.page) begin
				$error("page_out: expected %0d, got %0d", want.page, got_page);
				err_cnt++;
			end
			if (got_place !== want.place) begin
				$error("placement: expected %0d, got %0d", want.place, got_place);
				err_cnt++;
			end
			if (got_core !== want.core) begin
				$error("home_core: expected %0d, got %0d", want.core, got_core);
				err_cnt++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			core_pos   = 0;
			best_count = '0;
			best_core  = '0;
			page_total = '0;
			mode_q     = MODE_RESET;
			shift_q    = SHIFT_RESET;
			s_taken   <= 1'b0;
		end else begin
			s_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready)
				check_placement(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				tally_count(s_axis_tdata[PAGE_W-1:0], s_axis_tdata[PAGE_W +: COUNT_W]);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_POLICY_MODE)
					mode_q = cfg_data[MODE_W-1:0];
				else if (cfg_index == REG_DOMINANCE_SHIFT)
					shift_q = cfg_data[SHIFT_W-1:0];
				cfg_beats++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("page_home_core_placement_policy_top_tb: errors");
				$finish;
			end
		end
	end

	// count beats
	always @(negedge clk) begin
		count_beat_t b;
		if (arst_n && (!s_axis_tvalid || s_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (src_pct > 0 && $urandom_range(99) < src_pct) begin
				src_gap = $urandom_range(17);
				s_axis_tvalid <= 1'b0;
			end else if (beat_q.size() > 0) begin
				b = beat_q.pop_front();
				s_axis_tdata  <= {{(S_TDATA_W-PAGE_W-COUNT_W){1'b0}}, b.count, b.page};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (snk_gap > 0) begin
			snk_gap--;
			m_axis_tready <= 1'b0;
		end else if (snk_pct > 0 && $urandom_range(99) < snk_pct) begin
			snk_gap = $urandom_range(17);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int n0;
		n0 = cfg_beats;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (cfg_beats == n0);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [SHIFT_W-1:0] shift);
		write_reg(REG_POLICY_MODE, CFG_DATA_W'(($urandom_range(7) << MODE_W) | mode));
		write_reg(REG_DOMINANCE_SHIFT, shift);
	endtask

	task automatic queue_page(input page_kind_t kind, input logic [PAGE_W-1:0] page,
			input int hot, input bit drift);
		count_beat_t b;
		logic [COUNT_W-1:0] peak;
		if (hot < 0)
			hot = $urandom_range(NUM_CORES_DEF - 1);
		peak = ($urandom_range(3) == 0) ? COUNT_W'($urandom()) : COUNT_W'($urandom_range(4000));
		for (int c = 0; c < NUM_CORES_DEF; c++) begin
			b.page = drift ? PAGE_W'($urandom_range(1023)) : page;
			case (kind)
				PG_ZERO:      b.count = '0;
				PG_SPARSE:    b.count = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
				PG_DOMINANT:  b.count = (c == hot) ? peak : $urandom_range(63);
				PG_RANDOM:    b.count = $urandom();
				PG_TIES:      b.count = ($urandom_range(2) == 0) ? 0 : 7;
				PG_SATURATED: b.count = '1;
				default:      b.count = $urandom_range(4, 1);
			endcase
			beat_q.push_back(b);
		end
	endtask

	task automatic drain();
		while (beat_q.size() > 0 || s_axis_tvalid || placement_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [MODE_W-1:0]  mode;
		logic [SHIFT_W-1:0] shift;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: dominance test, shift of one
		queue_page(PG_ZERO, '0, -1, 1'b0);
		queue_page(PG_SATURATED, '1, -1, 1'b0);
		queue_page(PG_DOMINANT, 10'd512, NUM_CORES_DEF - 1, 1'b0);
		queue_page(PG_DOMINANT, 10'd341, 0, 1'b0);
		queue_page(PG_SPREAD, 10'd682, -1, 1'b0);
		queue_page(PG_TIES, 10'd17, -1, 1'b1);
		drain();

		for (int ph = 0; ph < 11; ph++) begin
			case (ph)
				0: begin mode = MODE_HASH_ALL; shift = '1; end
				1: begin mode = MODE_HOTTEST;  shift = '0; end
				2: begin mode = MODE_DOMINATE; shift = '0; end
				3: begin mode = MODE_UNUSED;   shift = '1; end
				4: begin mode = MODE_DOMINATE; shift = SHIFT_RESET; end
				default: begin
					mode  = MODE_W'($urandom_range(3));
					shift = $urandom_range(1) ? SHIFT_W'($urandom_range(31)) :
						SHIFT_W'($urandom_range(6));
				end
			endcase
			if (ph == 5)
				write_reg(CFG_IDX_W'(REG_FIRST_UNUSED + $urandom_range(13)),
					CFG_DATA_W'($urandom_range(31)));
			set_policy(mode, shift);
			if (ph == 10) begin
				src_pct = 0;
				snk_pct = 0;
			end else begin
				src_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
				snk_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
			end
			for (int p = 0; p < 2; p++)
				queue_page(page_kind_t'($urandom_range(PG_SPREAD)),
					PAGE_W'($urandom_range(1023)), -1, $urandom_range(9) == 0);
			drain();
		end

		repeat (8) @(negedge clk);
		if (err_cnt == 0)
			$display("page_home_core_placement_policy_top_tb: clean");
		else
			$display("page_home_core_placement_policy_top_tb: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/core/phcp_pkg.sv
rtl/core/phcp_accum.sv
rtl/core/phcp_decide.sv
rtl/core/page_home_core_placement_policy_top.sv
sim/page_home_core_placement_policy_top_tb.sv
